// ===== rtl/dcsq_pkg.sv =====
// Package for the DCS command queue packer: item and result types and
// packet type codes. No dependencies.
package dcsq_pkg;

  // DSI data types and header tag used in command queue words
  localparam logic [7:0] DcsShortNoParam  = 8'h05;
  localparam logic [7:0] DcsShortOneParam = 8'h15;
  localparam logic [7:0] DcsLongWrite     = 8'h39;
  localparam logic [7:0] DcsLongHeaderTag = 8'h02;

  localparam int ByteW  = 8;
  localparam int WordW  = 32;
  localparam int SlotW  = 7;
  localparam int LaneW  = 2;

  // One input byte with its command flag
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             is_command;
    logic [ByteW-1:0] param_count;
  } dcsq_item_t;

  // One command queue word with its slot and completion info
  typedef struct packed {
    logic [WordW-1:0] queue_word;
    logic [SlotW-1:0] queue_slot;
    logic             last_word;
    logic [SlotW-1:0] word_total;
  } dcsq_result_t;

endpackage

// ===== rtl/dcsq_if.sv =====
// Valid/ready channel interfaces for the byte input and the word output.
// Depends on dcsq_pkg for field widths.
interface dcsq_byte_if;
  logic                      valid;
  logic                      ready;
  logic [dcsq_pkg::ByteW-1:0] data_byte;
  logic                      is_command;
  logic [dcsq_pkg::ByteW-1:0] param_count;

  modport source (output valid, output data_byte, output is_command,
                  output param_count, input ready);
  modport sink   (input valid, input data_byte, input is_command,
                  input param_count, output ready);
endinterface

interface dcsq_word_if;
  logic                       valid;
  logic                       ready;
  logic [dcsq_pkg::WordW-1:0] queue_word;
  logic [dcsq_pkg::SlotW-1:0] queue_slot;
  logic                       last_word;
  logic [dcsq_pkg::SlotW-1:0] word_total;

  modport source (output valid, output queue_word, output queue_slot,
                  output last_word, output word_total, input ready);
  modport sink   (input valid, input queue_word, input queue_slot,
                  input last_word, input word_total, output ready);
endinterface

// ===== rtl/dcsq_pack_core.sv =====
// Packing state and per-byte next-state/result logic of the packer.
// Depends on dcsq_pkg.
module dcsq_pack_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  dcsq_pkg::dcsq_item_t   item,
  output logic                   has_result,
  output dcsq_pkg::dcsq_result_t result
);
  import dcsq_pkg::*;

  logic             active, active_next;
  logic             long_mode, long_mode_next;
  logic [ByteW-1:0] held_command, held_command_next;
  logic [ByteW-1:0] bytes_left, bytes_left_next;
  logic [LaneW-1:0] lane_in_word, lane_in_word_next;
  logic [WordW-1:0] word_accum, word_accum_next;
  logic [SlotW-1:0] slot_next, slot_next_next;
  logic [SlotW-1:0] words_expected, words_expected_next;

  logic [ByteW:0]   count_plus_one;
  logic [ByteW:0]   count_plus_four;
  logic [WordW-1:0] merged_word;
  logic [ByteW-1:0] left_dec;
  logic [LaneW-1:0] lane_inc;

  assign count_plus_one  = {1'b0, item.param_count} + (ByteW+1)'(1);
  assign count_plus_four = {1'b0, item.param_count} + (ByteW+1)'(4);
  assign merged_word     = word_accum | ({{(WordW-ByteW){1'b0}}, item.data_byte}
                                         << {lane_in_word, 3'b000});
  assign left_dec        = bytes_left - ByteW'(1);
  assign lane_inc        = lane_in_word + LaneW'(1);

  // Decide the next state and the word, if any, for this byte
  always_comb begin
    active_next         = active;
    long_mode_next      = long_mode;
    held_command_next   = held_command;
    bytes_left_next     = bytes_left;
    lane_in_word_next   = lane_in_word;
    word_accum_next     = word_accum;
    slot_next_next      = slot_next;
    words_expected_next = words_expected;
    has_result          = 1'b0;
    result              = '0;

    if (item.is_command) begin
      // Abandon anything unfinished, then start the new command
      active_next         = 1'b0;
      long_mode_next      = 1'b0;
      held_command_next   = '0;
      bytes_left_next     = '0;
      lane_in_word_next   = '0;
      word_accum_next     = '0;
      slot_next_next      = '0;
      words_expected_next = '0;
      priority if (item.param_count == '0) begin
        has_result        = 1'b1;
        result.queue_word = {8'h00, item.data_byte, DcsShortNoParam, 8'h00};
        result.last_word  = 1'b1;
        result.word_total = SlotW'(1);
      end else if (item.param_count == ByteW'(1)) begin
        active_next       = 1'b1;
        held_command_next = item.data_byte;
        bytes_left_next   = ByteW'(1);
      end else begin
        active_next         = 1'b1;
        long_mode_next      = 1'b1;
        bytes_left_next     = item.param_count;
        word_accum_next     = {{(WordW-ByteW){1'b0}}, item.data_byte};
        lane_in_word_next   = LaneW'(1);
        slot_next_next      = SlotW'(1);
        words_expected_next = count_plus_four[ByteW:2] + SlotW'(1);
        has_result          = 1'b1;
        result.queue_word   = {7'b0, count_plus_one, DcsLongWrite, DcsLongHeaderTag};
      end
    end else if (active && !long_mode) begin
      // Single parameter: emit the short word and drop back to idle
      has_result          = 1'b1;
      result.queue_word   = {item.data_byte, held_command, DcsShortOneParam, 8'h00};
      result.last_word    = 1'b1;
      result.word_total   = SlotW'(1);
      active_next         = 1'b0;
      held_command_next   = '0;
      bytes_left_next     = '0;
    end else if (active) begin
      // Pack the byte into the current payload word
      word_accum_next   = merged_word;
      lane_in_word_next = lane_inc;
      bytes_left_next   = left_dec;
      if (left_dec == '0) begin
        has_result          = 1'b1;
        result.queue_word   = merged_word;
        result.queue_slot   = slot_next;
        result.last_word    = 1'b1;
        result.word_total   = words_expected;
        active_next         = 1'b0;
        long_mode_next      = 1'b0;
        lane_in_word_next   = '0;
        word_accum_next     = '0;
        slot_next_next      = '0;
        words_expected_next = '0;
      end else if (lane_inc == '0) begin
        has_result        = 1'b1;
        result.queue_word = merged_word;
        result.queue_slot = slot_next;
        word_accum_next   = '0;
        slot_next_next    = slot_next + SlotW'(1);
      end
    end
  end

  // Advance the state on each processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      long_mode      <= 1'b0;
      held_command   <= '0;
      bytes_left     <= '0;
      lane_in_word   <= '0;
      word_accum     <= '0;
      slot_next      <= '0;
      words_expected <= '0;
    end else if (step) begin
      active         <= active_next;
      long_mode      <= long_mode_next;
      held_command   <= held_command_next;
      bytes_left     <= bytes_left_next;
      lane_in_word   <= lane_in_word_next;
      word_accum     <= word_accum_next;
      slot_next      <= slot_next_next;
      words_expected <= words_expected_next;
    end
  end

endmodule

// ===== rtl/dcs_command_queue_packer.sv =====
// Top level of the DCS command queue packer: input register, packing core,
// output register. Depends on dcsq_pkg, dcsq_if and dcsq_pack_core.
//
// Usage:
//   cmd_bytes carries one byte per transfer. A byte with is_command set is a
//   DCS command code and param_count gives the parameter bytes that follow;
//   other bytes are parameters. Bytes outside a command are dropped, and a
//   new command start abandons an unfinished one.
//   queue_words carries 32-bit command queue words with their slot number;
//   the final word of a command has last_word set and word_total gives the
//   number of words queued for it.
//   Throughput: one byte per cycle while queue_words is not held off; the
//   packing step between the input register and the output register is
//   combinational. A word completed by the byte in the input register is
//   loaded into the output register and offered on queue_words from there.
//   Stall: while queue_words is held off, the output register keeps its
//   word; one more byte is still taken into the input register, then
//   cmd_bytes.ready drops until the word leaves. Bytes that make no word
//   pass through regardless of the stall.
//   Reset: rst (synchronous) empties both registers and returns to idle.
module dcs_command_queue_packer (
  input logic        clk,
  input logic        rst,
  dcsq_byte_if.sink   cmd_bytes,
  dcsq_word_if.source queue_words
);
  import dcsq_pkg::*;

  logic         in_valid;
  dcsq_item_t   in_item;
  logic         out_valid;
  dcsq_result_t out_result;
  logic         core_has_result;
  dcsq_result_t core_result;
  logic         out_free;
  logic         in_go;

  assign out_free        = !out_valid || queue_words.ready;
  assign in_go           = in_valid && (!core_has_result || out_free);
  assign cmd_bytes.ready = !in_valid || in_go;

  // Hold the transferred byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd_bytes.ready) begin
      in_valid <= cmd_bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bytes.ready && cmd_bytes.valid) begin
      in_item.data_byte   <= cmd_bytes.data_byte;
      in_item.is_command  <= cmd_bytes.is_command;
      in_item.param_count <= cmd_bytes.param_count;
    end
  end

  dcsq_pack_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (in_go),
    .item       (in_item),
    .has_result (core_has_result),
    .result     (core_result)
  );

  // Load a new word or drop the one that left
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_go && core_has_result) begin
      out_valid <= 1'b1;
    end else if (queue_words.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && core_has_result) begin
      out_result <= core_result;
    end
  end

  assign queue_words.valid      = out_valid;
  assign queue_words.queue_word = out_result.queue_word;
  assign queue_words.queue_slot = out_result.queue_slot;
  assign queue_words.last_word  = out_result.last_word;
  assign queue_words.word_total = out_result.word_total;

`ifndef ASSERT_OFF
  // A word count appears only on the final word of a command
  a_total_only_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.last_word |-> out_result.word_total == '0)
    else $error("word_total set on a non-final word");

  // A final word always reports at least one queued word
  a_last_has_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.last_word |-> out_result.word_total != '0)
    else $error("final word reports zero words");

  // A held byte that cannot go keeps its place
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_go |=> in_valid && $stable(in_item))
    else $error("input byte lost while stalled");

  // A waiting word is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !queue_words.ready |-> !(in_go && core_has_result))
    else $error("output word overwritten while stalled");
`endif

endmodule
